FILE: rtl/core/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under an active-low reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication under an active-low reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/mbe_pkg.sv
`default_nettype none

package mbe_pkg;

  // fixed-point format and image geometry
  localparam int FracBits  = 28;
  localparam int ImageSize = 1024;
  localparam int PixW      = 10;
  localparam int CountW    = 16;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 32;

  localparam logic [PixW-1:0] PixClamp =
    PixW'(((ImageSize > (1 << PixW)) ? (1 << PixW) : ImageSize) - 1);

  // escape threshold 4.0 squared-magnitude, capped at 2^63
  localparam int ThrExp = ((2 * FracBits + 2) > 63) ? 63 : (2 * FracBits + 2);
  localparam logic [63:0] EscThr = 64'd1 << ThrExp;

  // register reset values
  localparam logic signed [31:0] LeftReset  = 32'shE000_0000;
  localparam logic signed [31:0] TopReset   = 32'shE800_0000;
  localparam logic [30:0]        XStepReset = 31'd786432;
  localparam logic [30:0]        YStepReset = 31'd786432;
  localparam logic [15:0]        LimitReset = 16'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEFT_EDGE  = 3'd0,
    CFG_TOP_EDGE   = 3'd1,
    CFG_X_STEP     = 3'd2,
    CFG_Y_STEP     = 3'd3,
    CFG_ITER_LIMIT = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_PX   = 3'd1,
    OP_PY   = 3'd2,
    OP_RR   = 3'd3,
    OP_II   = 3'd4,
    OP_RI   = 3'd5
  } opsel_e;

  typedef struct packed {
    logic [PixW-1:0] pixel_x;
    logic [PixW-1:0] pixel_y;
  } in_t;

  typedef struct packed {
    logic [CountW-1:0] iter_count;
    logic              escaped;
  } out_t;

  typedef struct packed {
    logic signed [31:0] left_edge;
    logic signed [31:0] top_edge;
    logic [30:0]        x_step;
    logic [30:0]        y_step;
    logic [15:0]        iteration_limit;
  } cfg_t;

  typedef struct packed {
    opsel_e op;
    logic   load;
    logic   cr_en;
    logic   ci_en;
    logic   rr_en;
    logic   ii_en;
    logic   z_en;
    logic   done;
  } ctrl_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < 64'shFFFF_FFFF_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mbe_cfg.sv
`default_nettype none

module mbe_cfg
  import mbe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_edge       <= LeftReset;
      cfg_q.top_edge        <= TopReset;
      cfg_q.x_step          <= XStepReset;
      cfg_q.y_step          <= YStepReset;
      cfg_q.iteration_limit <= LimitReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LEFT_EDGE:  cfg_q.left_edge       <= signed'(cfg_data_i);
        CFG_TOP_EDGE:   cfg_q.top_edge        <= signed'(cfg_data_i);
        CFG_X_STEP:     cfg_q.x_step          <= cfg_data_i[30:0];
        CFG_Y_STEP:     cfg_q.y_step          <= cfg_data_i[30:0];
        CFG_ITER_LIMIT: cfg_q.iteration_limit <= cfg_data_i[15:0];
        default: ; // unused index, write dropped
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mbe_mult.sv
`default_nettype none

module mbe_mult (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [63:0] prod_o
);

  logic signed [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(a_i) * 64'(b_i);
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

FILE: rtl/core/mbe_ctrl.sv
`default_nettype none

module mbe_ctrl
  import mbe_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [15:0]       limit_i,
  input  logic              esc_i,
  output ctrl_t             ctrl_o,
  output logic              busy_o,
  output logic [CountW-1:0] count_o
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_CX   = 8'b0000_0010,
    S_CY   = 8'b0000_0100,
    S_CI   = 8'b0000_1000,
    S_RR   = 8'b0001_0000,
    S_II   = 8'b0010_0000,
    S_MAG  = 8'b0100_0000,
    S_UPD  = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  ctrl_t             ctrl;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ctrl       = '0;
    ctrl.op    = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctrl.load = 1'b1;
          count_d   = '0;
          state_d   = S_CX;
        end
      end
      S_CX: begin
        ctrl.op = OP_PX;
        state_d = S_CY;
      end
      S_CY: begin
        ctrl.op    = OP_PY;
        ctrl.cr_en = 1'b1;
        state_d    = S_CI;
      end
      S_CI: begin
        ctrl.ci_en = 1'b1;
        state_d    = S_RR;
      end
      S_RR: begin
        ctrl.op = OP_RR;
        state_d = S_II;
      end
      S_II: begin
        ctrl.op    = OP_II;
        ctrl.rr_en = 1'b1;
        state_d    = S_MAG;
      end
      S_MAG: begin
        ctrl.op    = OP_RI;
        ctrl.ii_en = 1'b1;
        if (esc_i || (count_q == limit_i)) begin
          ctrl.done = 1'b1;
          state_d   = S_IDLE;
        end else begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        ctrl.z_en = 1'b1;
        count_d   = count_q + CountW'(1);
        state_d   = S_RR;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  assign ctrl_o  = ctrl;
  assign busy_o  = (state_q != S_IDLE);
  assign count_o = count_q;

endmodule

`default_nettype wire

FILE: rtl/core/mandelbrot_escape_time.sv
// escape-time engine: one pixel per command, iterating z = z*z + c in signed q4.28
// latency: result strobe 4*n + 6 cycles after the start transaction, n = iterations done
// throughput: next start accepted at the end of the strobe cycle, one pixel per 4*n + 7 cycles
// the figure is set by the single 32x32 multiplier: three products plus an update step
// reset: asynchronous active low, clears sequencer and strobe, loads register defaults
// results cannot be stalled: each is shown for one cycle and must be taken then
`default_nettype none

module mandelbrot_escape_time
  import mbe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // command channel
  input  logic                start,
  output logic                busy,
  input  in_t                 pixel_i,
  // result channel
  output logic                result_valid_o,
  output out_t                result_o,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t               cfg;
  ctrl_t              ctrl;
  logic [CountW-1:0]  count;

  // operand and product path of the shared multiplier
  logic signed [31:0] op_a, op_b;
  logic signed [63:0] prod;

  // per-pixel state
  logic [PixW-1:0]    px_q, py_q;
  logic signed [31:0] cr_q, ci_q;
  logic signed [31:0] zr_q, zi_q;
  logic signed [63:0] rr_q, ii_q;

  // arithmetic around the product register
  logic [PixW-1:0]    px_clamped, py_clamped;
  logic signed [63:0] re_full, im_full;
  logic [63:0]        mag;
  logic               esc;

  // result register
  logic               result_valid_q;
  out_t               result_q;

  mbe_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mbe_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .limit_i (cfg.iteration_limit),
    .esc_i   (esc),
    .ctrl_o  (ctrl),
    .busy_o  (busy),
    .count_o (count)
  );

  // operand selection, one product per cycle
  always_comb begin
    case (ctrl.op)
      OP_PX: begin
        op_a = signed'({{(32-PixW){1'b0}}, px_q});
        op_b = signed'({1'b0, cfg.x_step});
      end
      OP_PY: begin
        op_a = signed'({{(32-PixW){1'b0}}, py_q});
        op_b = signed'({1'b0, cfg.y_step});
      end
      OP_RR: begin
        op_a = zr_q;
        op_b = zr_q;
      end
      OP_II: begin
        op_a = zi_q;
        op_b = zi_q;
      end
      OP_RI: begin
        op_a = zr_q;
        op_b = zi_q;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  mbe_mult u_mult (
    .clk_i  (clk_i),
    .a_i    (op_a),
    .b_i    (op_b),
    .prod_o (prod)
  );

  // indices past the image edge sit on the last row or column
  assign px_clamped = (pixel_i.pixel_x > PixClamp) ? PixClamp : pixel_i.pixel_x;
  assign py_clamped = (pixel_i.pixel_y > PixClamp) ? PixClamp : pixel_i.pixel_y;

  // |z|^2 while the product register carries zi*zi, never wraps in 64 bits
  assign mag = unsigned'(rr_q) + unsigned'(prod);
  assign esc = (mag >= EscThr);

  // next z: arithmetic shift gives the floor, 2*zr*zi folded into the shift
  assign re_full = ((rr_q - ii_q) >>> FracBits) + 64'(cr_q);
  assign im_full = (prod >>> (FracBits - 1)) + 64'(ci_q);

  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      px_q <= px_clamped;
      py_q <= py_clamped;
      zr_q <= '0;
      zi_q <= '0;
    end else if (ctrl.z_en) begin
      zr_q <= sat32(re_full);
      zi_q <= sat32(im_full);
    end
    if (ctrl.cr_en) begin
      cr_q <= sat32(prod + 64'(cfg.left_edge));
    end
    if (ctrl.ci_en) begin
      ci_q <= sat32(prod + 64'(cfg.top_edge));
    end
    if (ctrl.rr_en) begin
      rr_q <= prod;
    end
    if (ctrl.ii_en) begin
      ii_q <= prod;
    end
    if (ctrl.done) begin
      result_q.iter_count <= count;
      result_q.escaped    <= esc;
    end
  end

  // one-cycle strobe for each finished pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= ctrl.done;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

`default_nettype wire

FILE: rtl/core/mbe_checker.sv
`default_nettype none
`include "assert_macros.svh"

module mbe_checker
  import mbe_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input in_t                 pixel_i,
  input logic                result_valid_o,
  input out_t                result_o,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic [CfgIdxW-1:0]  cfg_index_i,
  input logic [CfgDataW-1:0] cfg_data_i
);

  logic accept;
  logic cfg_write;

  assign accept    = start && !busy;
  assign cfg_write = cfg_valid_i && cfg_ready_o;

  // an accepted command keeps the engine busy
  `ASSERT_NXT(a_accept_busy, clk_i, rst_ni, accept, busy)
  // a result shows only once the engine has gone idle
  `ASSERT_IMP(a_result_idle, clk_i, rst_ni, result_valid_o, !busy)
  // busy drops only together with a result
  `ASSERT_IMP(a_busy_fall, clk_i, rst_ni, $fell(busy), result_valid_o)
  // no two results in a row, checked while no config write is taken
  `ASSERT_NXT(a_strobe_single, clk_i, rst_ni, result_valid_o && !cfg_write,
              !result_valid_o)

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (.*);

`default_nettype wire
